FILE: design/pckn_pkg.sv
// Shared types and constants for the per-class nearest-neighbor selector.
package pckn_pkg;

  localparam int unsigned INDEX_BITS   = 16;
  localparam int unsigned DIST_BITS    = 32;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned CLASS_W      = 3;
  localparam int unsigned RSLOT_W      = 4;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam logic [COUNT_W-1:0] K_RESET = 5'd10;

  typedef enum logic [0:0] {
    REG_NEIGHBOUR_COUNT = 1'b0,
    REG_QUERY_INDEX     = 1'b1
  } reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_OFFER = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CMP,
    S_READ,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [INDEX_BITS-1:0] cand_index;
    logic [CLASS_W-1:0]    class_id;
    logic [DIST_BITS-1:0]  cand_distance;
    logic [RSLOT_W-1:0]    read_slot;
  } item_t;

  typedef struct packed {
    logic                  accepted;
    logic                  bad_class;
    logic [RSLOT_W-1:0]    written_slot;
    logic [COUNT_W-1:0]    stored_count;
    logic [DIST_BITS-1:0]  worst_distance;
    logic [DIST_BITS-1:0]  entry_distance;
    logic [INDEX_BITS-1:0] entry_index;
    logic                  entry_valid;
  } result_t;

endpackage

FILE: design/per_class_knn_selector.sv
// Top level: command sequencer, per-class status, configuration port.
// Clear, read miss, bad class and self candidate are answered from the decide state; read hit
// and rejected candidate go through one memory read; an appended or replacement candidate is
// written and then the class's entries are swept for the new worst slot, one entry per cycle.
// One transaction at a time; busy drops in the strobe cycle. Reset clears class fill and
// status; K resets to 10, query to 0.
module per_class_knn_selector #(
  parameter int unsigned MAX_CLASSES = 8,
  parameter int unsigned MAX_K       = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  pckn_pkg::item_t                    item_i,
  output logic                               done_o,
  output pckn_pkg::result_t                  result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pckn_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pckn_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pckn_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import pckn_pkg::*;

  localparam int unsigned DEPTH  = MAX_CLASSES * MAX_K;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned SLOT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned KW     = $clog2(MAX_K + 1);

  // configuration
  logic [COUNT_W-1:0]    nc_q;
  logic [INDEX_BITS-1:0] qidx_q;
  logic                  cfg_wr;
  reg_e                  cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q   <= K_RESET;
      qidx_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_NEIGHBOUR_COUNT: nc_q   <= pwdata[COUNT_W-1:0];
        REG_QUERY_INDEX:     qidx_q <= pwdata[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_NEIGHBOUR_COUNT: prdata = CFG_DATA_W'(nc_q);
      REG_QUERY_INDEX:     prdata = CFG_DATA_W'(qidx_q);
      default:             prdata = '0;
    endcase
  end

  // effective K, clamped to 1..MAX_K
  logic [KW-1:0] k_eff;
  always_comb begin
    if (nc_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(nc_q) > MAX_K) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(nc_q);
    end
  end

  // sequencer state
  state_e  state_q, state_d;
  item_t   item_q;
  logic [KW-1:0]     issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic              done_q, done_d;
  result_t           res_q, res_d;

  // per-class status
  logic [KW-1:0]        fill_q   [MAX_CLASSES];
  logic [SLOT_W-1:0]    wslot_q  [MAX_CLASSES];
  logic [DIST_BITS-1:0] cworst_q [MAX_CLASSES];

  logic [CLS_W-1:0]     cls_idx;
  logic [KW-1:0]        fill_c;
  logic [SLOT_W-1:0]    wslot_c;
  logic [DIST_BITS-1:0] cworst_c;
  logic                 cls_bad;
  logic                 self_cand;
  logic                 rd_hit;
  logic [AW-1:0]        base_addr;

  logic clr, app, fin;

  // memory and scan unit
  logic                  mem_we;
  logic [SLOT_W-1:0]     wslot_sel;
  logic [SLOT_W-1:0]     rslot_sel;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [DIST_BITS-1:0]  mem_rdist;
  logic [INDEX_BITS-1:0] mem_rindex;
  logic [SLOT_W-1:0]     scan_best;
  logic [DIST_BITS-1:0]  scan_worst;

  assign cls_idx   = CLS_W'(item_q.class_id);
  assign fill_c    = fill_q[cls_idx];
  assign wslot_c   = wslot_q[cls_idx];
  assign cworst_c  = cworst_q[cls_idx];
  assign cls_bad   = 32'(item_q.class_id) >= MAX_CLASSES;
  assign self_cand = item_q.cand_index == qidx_q;
  assign rd_hit    = (32'(item_q.read_slot) < 32'(fill_c)) && (32'(item_q.read_slot) < MAX_K);
  assign base_addr = AW'(32'(cls_idx) * MAX_K);
  assign mem_waddr = AW'(base_addr + AW'(wslot_sel));
  assign mem_raddr = AW'(base_addr + AW'(rslot_sel));

  pckn_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdist_i  (item_q.cand_distance),
    .windex_i (item_q.cand_index),
    .raddr_i  (mem_raddr),
    .rdist_o  (mem_rdist),
    .rindex_o (mem_rindex)
  );

  pckn_scan #(
    .SLOT_W (SLOT_W)
  ) u_scan (
    .clk_i        (clk_i),
    .valid_i      (pend_q),
    .slot_i       (pend_slot_q),
    .dist_i       (mem_rdist),
    .best_slot_o  (scan_best),
    .worst_dist_o (scan_worst)
  );

  assign busy = state_q != S_IDLE;

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    pend_slot_d = pend_slot_q;
    wr_slot_d   = wr_slot_q;
    done_d      = 1'b0;
    res_d       = '0;
    clr         = 1'b0;
    app         = 1'b0;
    fin         = 1'b0;
    mem_we      = 1'b0;
    wslot_sel   = '0;
    rslot_sel   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (item_q.mode)
          MODE_CLEAR: begin
            clr     = 1'b1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          MODE_OFFER: begin
            if (cls_bad) begin
              res_d.bad_class = 1'b1;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end else if (self_cand) begin
              res_d.stored_count   = COUNT_W'(fill_c);
              res_d.worst_distance = cworst_c;
              done_d               = 1'b1;
              state_d              = S_IDLE;
            end else if (fill_c < k_eff) begin
              wslot_sel = SLOT_W'(fill_c);
              mem_we    = 1'b1;
              app       = 1'b1;
              wr_slot_d = SLOT_W'(fill_c);
              issue_d   = '0;
              state_d   = S_SCAN;
            end else begin
              rslot_sel = wslot_c;
              state_d   = S_CMP;
            end
          end
          MODE_READ: begin
            if (cls_bad) begin
              res_d.bad_class = 1'b1;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end else if (rd_hit) begin
              rslot_sel = SLOT_W'(item_q.read_slot);
              state_d   = S_READ;
            end else begin
              res_d.stored_count   = COUNT_W'(fill_c);
              res_d.worst_distance = cworst_c;
              done_d               = 1'b1;
              state_d              = S_IDLE;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_CMP: begin
        if (item_q.cand_distance < mem_rdist) begin
          wslot_sel = wslot_c;
          mem_we    = 1'b1;
          wr_slot_d = wslot_c;
          issue_d   = '0;
          state_d   = S_SCAN;
        end else begin
          res_d.stored_count   = COUNT_W'(fill_c);
          res_d.worst_distance = cworst_c;
          done_d               = 1'b1;
          state_d              = S_IDLE;
        end
      end

      S_READ: begin
        res_d.stored_count   = COUNT_W'(fill_c);
        res_d.worst_distance = cworst_c;
        res_d.entry_distance = mem_rdist;
        res_d.entry_index    = mem_rindex;
        res_d.entry_valid    = 1'b1;
        done_d               = 1'b1;
        state_d              = S_IDLE;
      end

      S_SCAN: begin
        // read issue runs one slot ahead of the compare
        if (issue_q < fill_c) begin
          rslot_sel   = SLOT_W'(issue_q);
          pend_d      = 1'b1;
          pend_slot_d = SLOT_W'(issue_q);
          issue_d     = KW'(issue_q + 1'b1);
        end else begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        fin                  = 1'b1;
        res_d.accepted       = 1'b1;
        res_d.written_slot   = RSLOT_W'(wr_slot_q);
        res_d.stored_count   = COUNT_W'(fill_c);
        res_d.worst_distance = scan_worst;
        done_d               = 1'b1;
        state_d              = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      item_q <= item_i;
    end
    pend_slot_q <= pend_slot_d;
    wr_slot_q   <= wr_slot_d;
    res_q       <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
        fill_q[c]   <= '0;
        wslot_q[c]  <= '0;
        cworst_q[c] <= '0;
      end
    end else if (clr) begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
        fill_q[c]   <= '0;
        wslot_q[c]  <= '0;
        cworst_q[c] <= '0;
      end
    end else begin
      if (app) begin
        fill_q[cls_idx] <= KW'(fill_c + 1'b1);
      end
      if (fin) begin
        wslot_q[cls_idx]  <= scan_best;
        cworst_q[cls_idx] <= scan_worst;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: design/pckn_mem.sv
// Neighbor storage: distance and index per slot, one write and one registered read port.
module pckn_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AW-1:0]                   waddr_i,
  input  logic [pckn_pkg::DIST_BITS-1:0]  wdist_i,
  input  logic [pckn_pkg::INDEX_BITS-1:0] windex_i,
  input  logic [AW-1:0]                   raddr_i,
  output logic [pckn_pkg::DIST_BITS-1:0]  rdist_o,
  output logic [pckn_pkg::INDEX_BITS-1:0] rindex_o
);
  import pckn_pkg::*;

  logic [DIST_BITS-1:0]  dist_ram_q  [DEPTH];
  logic [INDEX_BITS-1:0] index_ram_q [DEPTH];
  logic [DIST_BITS-1:0]  rdist_q;
  logic [INDEX_BITS-1:0] rindex_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dist_ram_q[waddr_i]  <= wdist_i;
      index_ram_q[waddr_i] <= windex_i;
    end
    rdist_q  <= dist_ram_q[raddr_i];
    rindex_q <= index_ram_q[raddr_i];
  end

  assign rdist_o  = rdist_q;
  assign rindex_o = rindex_q;

endmodule

FILE: design/pckn_scan.sv
// Shared compare unit: tracks the first maximum distance over a slot sweep.
module pckn_scan #(
  parameter int unsigned SLOT_W = 4
) (
  input  logic                           clk_i,
  input  logic                           valid_i,
  input  logic [SLOT_W-1:0]              slot_i,
  input  logic [pckn_pkg::DIST_BITS-1:0] dist_i,
  output logic [SLOT_W-1:0]              best_slot_o,
  output logic [pckn_pkg::DIST_BITS-1:0] worst_dist_o
);
  import pckn_pkg::*;

  logic [SLOT_W-1:0]    best_q, best_d;
  logic [DIST_BITS-1:0] worst_q, worst_d;
  logic                 take;

  // slot zero opens a new sweep
  assign take = valid_i && ((slot_i == '0) || (dist_i > worst_q));

  always_comb begin
    best_d  = best_q;
    worst_d = worst_q;
    if (take) begin
      best_d  = slot_i;
      worst_d = dist_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    worst_q <= worst_d;
  end

  assign best_slot_o  = best_q;
  assign worst_dist_o = worst_q;

endmodule

FILE: bench/testbench.sv
// Testbench for per_class_knn_selector: directed and random commands checked by a predictor.
`timescale 1ns / 1ps

module testbench;
  import pckn_pkg::*;

  localparam int unsigned TB_CLASSES = 8;
  localparam int unsigned NUM_K = 16;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned PHASE_ITEMS = 200;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  item_t item_i = '0;
  logic done_o;
  result_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // predictor state
  logic [DIST_BITS-1:0] nn_dist [TB_CLASSES][NUM_K];
  logic [INDEX_BITS-1:0] nn_idx [TB_CLASSES][NUM_K];
  logic [COUNT_W-1:0] class_fill [TB_CLASSES];
  logic [RSLOT_W-1:0] worst_slot [TB_CLASSES];
  logic [DIST_BITS-1:0] class_worst [TB_CLASSES];
  logic [COUNT_W-1:0] k_reg = K_RESET;
  logic [INDEX_BITS-1:0] query_reg = '0;

  result_t knn_results_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 15;
  logic [CLASS_W-1:0] focus_a = '0;
  logic [CLASS_W-1:0] focus_b = '0;

  per_class_knn_selector uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_knn_state();
    for (int c = 0; c < TB_CLASSES; c++) begin
      for (int j = 0; j < NUM_K; j++) begin
        nn_dist[c][j] = '0;
        nn_idx[c][j] = '0;
      end
      class_fill[c] = '0;
      worst_slot[c] = '0;
      class_worst[c] = '0;
    end
  endfunction

  // first maximum wins on ties
  function automatic void rescan_class(int unsigned c);
    int unsigned n;
    logic [DIST_BITS-1:0] wv;
    logic [RSLOT_W-1:0] ws;
    n = class_fill[c];
    wv = '0;
    ws = '0;
    if (n > NUM_K) n = NUM_K;
    for (int unsigned j = 0; j < n; j++) begin
      if (j == 0 || nn_dist[c][j] > wv) begin
        wv = nn_dist[c][j];
        ws = RSLOT_W'(j);
      end
    end
    worst_slot[c] = ws;
    class_worst[c] = wv;
  endfunction

  function automatic result_t predict_knn_step(item_t it);
    result_t r;
    int unsigned k;
    int unsigned c;
    int unsigned fill;
    int unsigned ws;
    r = '0;
    k = k_reg;
    if (k < 1) k = 1;
    if (k > NUM_K) k = NUM_K;
    if (it.mode == MODE_CLEAR) begin
      clear_knn_state();
      return r;
    end
    if (it.mode == MODE_UNUSED) return r;
    if (int'(it.class_id) >= TB_CLASSES) begin
      r.bad_class = 1'b1;
      return r;
    end
    c = it.class_id;
    if (it.mode == MODE_OFFER) begin
      if (it.cand_index != query_reg) begin
        fill = class_fill[c];
        if (fill < k) begin
          nn_dist[c][fill] = it.cand_distance;
          nn_idx[c][fill] = it.cand_index;
          class_fill[c] = COUNT_W'(fill + 1);
          rescan_class(c);
          r.accepted = 1'b1;
          r.written_slot = RSLOT_W'(fill);
        end else begin
          ws = worst_slot[c];
          if (it.cand_distance < nn_dist[c][ws]) begin
            nn_dist[c][ws] = it.cand_distance;
            nn_idx[c][ws] = it.cand_index;
            rescan_class(c);
            r.accepted = 1'b1;
            r.written_slot = RSLOT_W'(ws);
          end
        end
      end
    end else if (it.read_slot < class_fill[c]) begin
      r.entry_distance = nn_dist[c][it.read_slot];
      r.entry_index = nn_idx[c][it.read_slot];
      r.entry_valid = 1'b1;
    end
    r.stored_count = class_fill[c];
    r.worst_distance = class_worst[c];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (knn_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", result_o);
      end else begin
        want = knn_results_q.pop_front();
        check_field("accepted", want.accepted, result_o.accepted);
        check_field("bad_class", want.bad_class, result_o.bad_class);
        check_field("written_slot", want.written_slot, result_o.written_slot);
        check_field("stored_count", want.stored_count, result_o.stored_count);
        check_field("worst_distance", want.worst_distance, result_o.worst_distance);
        check_field("entry_distance", want.entry_distance, result_o.entry_distance);
        check_field("entry_index", want.entry_index, result_o.entry_index);
        check_field("entry_valid", want.entry_valid, result_o.entry_valid);
      end
    end
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    knn_results_q.push_back(predict_knn_step(it));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (knn_results_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  // write, then read back
  task automatic cfg_write(input reg_e r, input logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (r == REG_NEIGHBOUR_COUNT) begin
      k_reg = value[COUNT_W-1:0];
      want = 32'(value[COUNT_W-1:0]);
    end else begin
      query_reg = value[INDEX_BITS-1:0];
      want = 32'(value[INDEX_BITS-1:0]);
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field(r == REG_NEIGHBOUR_COUNT ? "neighbour_count readback" : "query_index readback",
                want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic item_t make_item(logic [MODE_W-1:0] m, logic [INDEX_BITS-1:0] idx,
                                      logic [CLASS_W-1:0] cls, logic [DIST_BITS-1:0] dval,
                                      logic [RSLOT_W-1:0] slot);
    item_t it;
    it.mode = m;
    it.cand_index = idx;
    it.class_id = cls;
    it.cand_distance = dval;
    it.read_slot = slot;
    return it;
  endfunction

  // ties, extremes and full-range values
  function automatic logic [DIST_BITS-1:0] random_distance();
    case ($urandom_range(0, 9))
      0, 1: return DIST_BITS'($urandom_range(0, 7));
      2: return $urandom_range(0, 1) ? '1 : '0;
      3: return '1 - DIST_BITS'($urandom_range(0, 7));
      default: return DIST_BITS'($urandom);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned sel;
    it.cand_index = INDEX_BITS'($urandom);
    it.class_id = CLASS_W'($urandom);
    it.cand_distance = DIST_BITS'($urandom);
    it.read_slot = RSLOT_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 1) it.mode = MODE_CLEAR;
    else if (sel < 3) it.mode = MODE_UNUSED;
    else if (sel < 68) it.mode = MODE_OFFER;
    else it.mode = MODE_READ;
    sel = $urandom_range(0, 99);
    if (sel < 55) it.class_id = focus_a;
    else if (sel < 75) it.class_id = focus_b;
    if (it.mode == MODE_OFFER) begin
      it.cand_distance = random_distance();
      if ($urandom_range(0, 99) < 12) it.cand_index = query_reg;
    end
    return it;
  endfunction

  task automatic test_empty_and_extremes();
    send_item(make_item(MODE_READ, 16'h0000, 3'd0, 32'h0, 4'd0));
    send_item(make_item(MODE_OFFER, 16'h0000, 3'd0, 32'h5, 4'd0));
    send_item(make_item(MODE_OFFER, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 4'd0));
    send_item(make_item(MODE_OFFER, 16'h0001, 3'd7, 32'h0, 4'd0));
    send_item(make_item(MODE_OFFER, 16'h0002, 3'd7, 32'hFFFF_FFFF, 4'd0));
    send_item(make_item(MODE_READ, 16'h0000, 3'd7, 32'h0, 4'd2));
    send_item(make_item(MODE_READ, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 4'd15));
    send_item(make_item(MODE_UNUSED, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 4'd15));
    send_item(make_item(MODE_CLEAR, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 4'd15));
    send_item(make_item(MODE_READ, 16'h0000, 3'd7, 32'h0, 4'd0));
  endtask

  task automatic test_single_neighbour();
    wait_idle();
    cfg_write(REG_NEIGHBOUR_COUNT, 32'd1);
    send_item(make_item(MODE_OFFER, 16'd7, 3'd3, 32'd100, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd8, 3'd3, 32'd100, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd9, 3'd3, 32'd99, 4'd0));
    wait_idle();
    cfg_write(REG_NEIGHBOUR_COUNT, 32'd0);
    send_item(make_item(MODE_OFFER, 16'd10, 3'd3, 32'd98, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd11, 3'd3, 32'd200, 4'd0));
    send_item(make_item(MODE_READ, 16'd0, 3'd3, 32'd0, 4'd0));
  endtask

  // fill above K, then lower K so the class only replaces
  task automatic test_lowered_count();
    wait_idle();
    cfg_write(REG_NEIGHBOUR_COUNT, 32'd31);
    cfg_write(REG_QUERY_INDEX, 32'hFFFF);
    send_item(make_item(MODE_OFFER, 16'hFFFF, 3'd5, 32'd1, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd20, 3'd5, 32'd50, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd21, 3'd5, 32'd40, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd22, 3'd5, 32'd60, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd23, 3'd5, 32'd60, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd24, 3'd5, 32'd10, 4'd0));
    wait_idle();
    cfg_write(REG_NEIGHBOUR_COUNT, 32'd2);
    send_item(make_item(MODE_OFFER, 16'd25, 3'd5, 32'd55, 4'd0));
    send_item(make_item(MODE_OFFER, 16'd26, 3'd5, 32'd70, 4'd0));
    send_item(make_item(MODE_READ, 16'd0, 3'd5, 32'd0, 4'd3));
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0] k_values [9];
    k_values = '{5'd10, 5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd5};
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      cfg_write(REG_NEIGHBOUR_COUNT, 32'(k_values[p]));
      case (p % 3)
        0: cfg_write(REG_QUERY_INDEX, 32'h0000);
        1: cfg_write(REG_QUERY_INDEX, 32'hFFFF);
        default: cfg_write(REG_QUERY_INDEX, 32'($urandom_range(0, 65535)));
      endcase
      sender_idle_pct = (p < 3) ? 15 : (p < 6) ? 54 : 0;
      focus_a = CLASS_W'($urandom);
      focus_b = CLASS_W'($urandom);
      repeat (PHASE_ITEMS) send_item(random_item());
    end
  endtask

  initial begin
    clear_knn_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_extremes();
    test_single_neighbour();
    test_lowered_count();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
